// File: hw/rtl/nca_pkg.sv
package nca_pkg;

    // default sizes of the stores
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_FEATURES_DEF = 16;

    // payload field widths
    localparam int FUNC_W          = 1;
    localparam int CLUSTER_IDX_W   = 3;
    localparam int FEATURE_IDX_W   = 4;
    localparam int VALUE_W         = 16;
    localparam int CLUSTER_OUT_W   = 3;
    localparam int DIST_W          = 36;

    // arithmetic widths
    localparam int MAG_W  = 16;
    localparam int TERM_W = 32;
    localparam int ACC_W  = 37;

    // configuration port
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 5;
    localparam int CLUSTER_COUNT_W  = 4;
    localparam int FEATURE_COUNT_W  = 5;
    localparam logic [CLUSTER_COUNT_W-1:0] CLUSTER_COUNT_RST = 4'd8;
    localparam logic [FEATURE_COUNT_W-1:0] FEATURE_COUNT_RST = 5'd16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLUSTER_COUNT = 2'd0,
        REG_FEATURE_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_CENTROID = 1'b0,
        FUNC_FEATURE        = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic cwrite;
        logic issue;
        logic load_out;
        logic clear_acc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic feature_ok;
        logic is_write;
        logic last;
        logic issue_last;
        logic pipe_busy;
    } status_t;

endpackage

// File: hw/rtl/nca_sample_if.sv
interface nca_sample_if;
    logic                               valid;
    logic                               ready;
    logic [nca_pkg::FUNC_W-1:0]         func;
    logic [nca_pkg::CLUSTER_IDX_W-1:0]  cluster_index;
    logic [nca_pkg::FEATURE_IDX_W-1:0]  feature_index;
    logic signed [nca_pkg::VALUE_W-1:0] sample_value;

    modport source (
        output valid, func, cluster_index, feature_index, sample_value,
        input  ready
    );
    modport sink (
        input  valid, func, cluster_index, feature_index, sample_value,
        output ready
    );
endinterface

// File: hw/rtl/nca_result_if.sv
interface nca_result_if;
    logic                               valid;
    logic                               ready;
    logic [nca_pkg::CLUSTER_OUT_W-1:0]  nearest_cluster;
    logic [nca_pkg::DIST_W-1:0]         distance_squared;

    modport source (
        output valid, nearest_cluster, distance_squared,
        input  ready
    );
    modport sink (
        input  valid, nearest_cluster, distance_squared,
        output ready
    );
endinterface

// File: hw/rtl/nca_cfg_if.sv
interface nca_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nca_pkg::CFG_INDEX_W-1:0]  reg_index;
    logic [nca_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, reg_index, data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, data,
        output ready
    );
endinterface

// File: hw/rtl/nca_datapath.sv
module nca_datapath #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_FEATURES = nca_pkg::MAX_FEATURES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nca_pkg::cmd_t                        cmd,
    output nca_pkg::status_t                     status,
    input  logic [nca_pkg::FUNC_W-1:0]           in_func,
    input  logic [nca_pkg::CLUSTER_IDX_W-1:0]    in_cluster_index,
    input  logic [nca_pkg::FEATURE_IDX_W-1:0]    in_feature_index,
    input  logic signed [nca_pkg::VALUE_W-1:0]   in_sample_value,
    input  logic                                 cfg_we,
    input  logic [nca_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [nca_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [nca_pkg::CLUSTER_OUT_W-1:0]    out_cluster,
    output logic [nca_pkg::DIST_W-1:0]           out_distance
);

    localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int NCW   = $clog2(MAX_CLUSTERS + 1);
    localparam int NFW   = $clog2(MAX_FEATURES + 1);
    localparam int VW    = nca_pkg::VALUE_W;
    localparam int AccW  = nca_pkg::ACC_W;

    // configuration
    logic [nca_pkg::CLUSTER_COUNT_W-1:0] cluster_count_reg;
    logic [nca_pkg::FEATURE_COUNT_W-1:0] feature_count_reg;
    logic [NCW-1:0] nc;
    logic [NFW-1:0] nf;

    // latched feature
    logic signed [VW-1:0]                value_reg;
    logic [nca_pkg::FEATURE_IDX_W-1:0]   fidx_reg;
    logic                                last_reg;

    // stores
    logic signed [VW-1:0] centroid_mem [DEPTH];
    logic [AccW-1:0]      acc_mem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] acc_valid_reg;

    // pipeline
    logic [CW-1:0]        k_reg;
    logic                 s1_v_reg;
    logic [CW-1:0]        s1_k_reg;
    logic                 s1_accv_reg;
    logic signed [VW-1:0] c_rd_reg;
    logic [AccW-1:0]      acc_rd_reg;
    logic                 s2_v_reg;
    logic [CW-1:0]        s2_k_reg;
    logic [AccW-1:0]      s2_acc_reg;
    logic [nca_pkg::TERM_W-1:0] term_reg;

    logic [AccW-1:0] best_reg;
    logic [CW-1:0]   best_k_reg;
    logic [nca_pkg::CLUSTER_OUT_W-1:0] out_cluster_reg;
    logic [nca_pkg::DIST_W-1:0]        out_dist_reg;

    logic                       cwrite_ok;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic signed [VW:0]         diff;
    logic [nca_pkg::MAG_W-1:0]  mag;
    logic [nca_pkg::TERM_W-1:0] term_next;
    logic [AccW:0]              sum;
    logic [AccW-1:0]            acc_next;
    logic                       best_take;

    // effective counts, saturated into range
    always_comb
    begin
        if (cluster_count_reg == '0)
            nc = NCW'(1);
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
            nc = NCW'(MAX_CLUSTERS);
        else
            nc = NCW'(cluster_count_reg);

        if (feature_count_reg == '0)
            nf = NFW'(1);
        else if (32'(feature_count_reg) > MAX_FEATURES)
            nf = NFW'(MAX_FEATURES);
        else
            nf = NFW'(feature_count_reg);
    end

    assign status.feature_ok = (in_func == nca_pkg::FUNC_FEATURE)
                               && (32'(in_feature_index) < 32'(nf));
    assign status.is_write   = (in_func == nca_pkg::FUNC_WRITE_CENTROID);
    assign status.last       = last_reg;
    assign status.issue_last = (k_reg == CW'(MAX_CLUSTERS - 1));
    assign status.pipe_busy  = s1_v_reg | s2_v_reg;

    assign cwrite_ok = cmd.cwrite && (32'(in_cluster_index) < MAX_CLUSTERS)
                       && (32'(in_feature_index) < MAX_FEATURES);
    assign waddr = AW'(32'(in_cluster_index) * MAX_FEATURES + 32'(in_feature_index));
    assign raddr = AW'(32'(k_reg) * MAX_FEATURES + 32'(fidx_reg));

    // stage 1: difference and square
    assign diff      = (VW+1)'(c_rd_reg) - (VW+1)'(value_reg);
    assign mag       = diff[VW] ? nca_pkg::MAG_W'(-diff) : diff[VW-1:0];
    assign term_next = nca_pkg::TERM_W'(mag) * nca_pkg::TERM_W'(mag);

    // stage 2: accumulate with saturation, running minimum
    assign sum       = {1'b0, s2_acc_reg} + (AccW+1)'(term_reg);
    assign acc_next  = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    assign best_take = s2_v_reg && (32'(s2_k_reg) < 32'(nc))
                       && ((s2_k_reg == '0) || (acc_next < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= nca_pkg::CLUSTER_COUNT_RST;
            feature_count_reg <= nca_pkg::FEATURE_COUNT_RST;
            k_reg             <= '0;
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            acc_valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nca_pkg::REG_CLUSTER_COUNT:
                        cluster_count_reg <= cfg_data[nca_pkg::CLUSTER_COUNT_W-1:0];
                    nca_pkg::REG_FEATURE_COUNT:
                        feature_count_reg <= cfg_data[nca_pkg::FEATURE_COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.latch)
                k_reg <= '0;
            else if (cmd.issue)
                k_reg <= k_reg + CW'(1);

            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;

            if (cmd.clear_acc)
                acc_valid_reg <= '0;
            else if (s2_v_reg)
                acc_valid_reg[s2_k_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            value_reg <= in_sample_value;
            fidx_reg  <= in_feature_index;
            last_reg  <= (32'(in_feature_index) == 32'(nf) - 32'd1);
        end

        if (cwrite_ok)
            centroid_mem[waddr] <= in_sample_value;

        if (cmd.issue)
        begin
            c_rd_reg    <= centroid_mem[raddr];
            acc_rd_reg  <= acc_mem[k_reg];
            s1_k_reg    <= k_reg;
            s1_accv_reg <= acc_valid_reg[k_reg] && (fidx_reg != '0);
        end

        s2_k_reg   <= s1_k_reg;
        s2_acc_reg <= s1_accv_reg ? acc_rd_reg : '0;
        term_reg   <= term_next;

        if (s2_v_reg)
            acc_mem[s2_k_reg] <= acc_next;

        if (best_take)
        begin
            best_reg   <= acc_next;
            best_k_reg <= s2_k_reg;
        end

        if (cmd.load_out)
        begin
            out_cluster_reg <= nca_pkg::CLUSTER_OUT_W'(best_k_reg);
            out_dist_reg    <= best_reg[AccW-1] ? {nca_pkg::DIST_W{1'b1}}
                                                : best_reg[nca_pkg::DIST_W-1:0];
        end
    end

    assign out_cluster  = out_cluster_reg;
    assign out_distance = out_dist_reg;

endmodule

// File: hw/rtl/nca_ctrl.sv
module nca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nca_pkg::status_t  status,
    output nca_pkg::cmd_t     cmd
);

    nca_pkg::state_t state_reg;
    nca_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nca_pkg::ST_IDLE:
                if (in_valid && status.feature_ok)
                    state_next = nca_pkg::ST_RUN;
            nca_pkg::ST_RUN:
                if (status.issue_last)
                    state_next = nca_pkg::ST_DRAIN;
            nca_pkg::ST_DRAIN:
                if (!status.pipe_busy)
                    state_next = status.last ? nca_pkg::ST_FINISH : nca_pkg::ST_IDLE;
            nca_pkg::ST_FINISH:
                if (out_free)
                    state_next = nca_pkg::ST_IDLE;
            default:
                state_next = nca_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            nca_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.latch  = in_valid;
                cmd.cwrite = in_valid && status.is_write;
            end
            nca_pkg::ST_RUN:
                cmd.issue = 1'b1;
            nca_pkg::ST_DRAIN:
            begin
            end
            nca_pkg::ST_FINISH:
            begin
                cmd.load_out  = out_free;
                cmd.clear_acc = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nca_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // result is only taken once every cluster has left the pipeline
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.pipe_busy)
        else $error("result loaded while pipeline busy");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    // last cluster issued moves the sequencer on to drain
    a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nca_pkg::ST_RUN && status.issue_last)
        |=> (state_reg == nca_pkg::ST_DRAIN))
        else $error("sequencer did not leave run");

endmodule

// File: hw/rtl/nearest_centroid_assign.sv
// nearest centroid classifier with squared euclidean distance
//
// sample channel: each item is either a centroid element write (func = 0,
// stored at cluster_index/feature_index) or one feature of a sample
// (func = 1). features update one 37-bit accumulator per cluster; the feature
// at index feature_count-1 produces one result item on the result channel:
// the nearest cluster (ties to the lowest index) and its squared distance.
// cfg channel: index 0 cluster_count, index 1 feature_count, always ready;
// write only while the block is idle.
//
// timing: a centroid write is stored when it is accepted. a feature goes
// one cycle per cluster through the single centroid read port and the
// shared squaring multiplier, then drains through the three-stage
// read/square/accumulate pipeline; no new item is taken meanwhile. the last
// feature of a sample then loads the result register once it is free.
// reset clears the accumulators (valid bits) and sets the registers to 8 and
// 16; the centroid store holds nothing until written. if the receiver stalls,
// the result waits in its register and the next sample can still be fed in
// up to its last feature, which then waits until the result is taken.
module nearest_centroid_assign #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_FEATURES = nca_pkg::MAX_FEATURES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    nca_sample_if.sink    sample,
    nca_result_if.source  result,
    nca_cfg_if.sink       cfg
);

    nca_pkg::cmd_t    cmd;
    nca_pkg::status_t status;

    // configuration registers take a write every cycle
    assign cfg.ready = 1'b1;

    // sequencer: accept, issue one cluster per cycle, drain, deliver
    nca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, squaring pipeline, minimum search and result register
    nca_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_func          (sample.func),
        .in_cluster_index (sample.cluster_index),
        .in_feature_index (sample.feature_index),
        .in_sample_value  (sample.sample_value),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.reg_index),
        .cfg_data         (cfg.data),
        .out_cluster      (result.nearest_cluster),
        .out_distance     (result.distance_squared)
    );

endmodule

// File: test/tb_nearest_centroid_assign.sv
module tb_nearest_centroid_assign;
    import nca_pkg::*;

    // sizes of the block under test
    localparam int NUM_CLUSTERS = MAX_CLUSTERS_DEF;
    localparam int NUM_FEATURES = MAX_FEATURES_DEF;

    // saturation points of the accumulators and of the emitted distance
    localparam longint unsigned ACC_SAT  = (64'd1 << ACC_W) - 64'd1;
    localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;

    // extremes of a signed feature or centroid element
    localparam logic signed [VALUE_W-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 16'sh7FFF;

    // register indexes the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // column used to drive the accumulators into saturation
    localparam int SAT_COL = 3;

    // time to let a feature drain through the block, with margin
    localparam int SETTLE_CYCLES = 3 * (NUM_CLUSTERS + 5);
    // long receiver hold-off that fills the block
    localparam int HOLD_CYCLES   = 1500;
    // cycles without any accepted item before the run is abandoned
    localparam int IDLE_LIMIT    = 6000;
    // items per random phase, nine phases
    localparam int PHASE_ITEMS   = 62;
    localparam int PLAN_LEN      = 9;

    typedef struct {
        logic [CLUSTER_OUT_W-1:0] cluster;
        logic [DIST_W-1:0]        distance;
    } assignment_t;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // predicts nearest-centroid assignments and checks them as they come out
    class assignment_checker;
        logic signed [VALUE_W-1:0]  centroid_mem [NUM_CLUSTERS*NUM_FEATURES];
        logic [ACC_W-1:0]           dist_acc [NUM_CLUSTERS];
        logic [CLUSTER_COUNT_W-1:0] cluster_count_reg;
        logic [FEATURE_COUNT_W-1:0] feature_count_reg;
        assignment_t                predicted_q [$];
        int unsigned                mismatches;

        function new();
            foreach (centroid_mem[i]) centroid_mem[i] = '0;
            foreach (dist_acc[k]) dist_acc[k] = '0;
            cluster_count_reg = CLUSTER_COUNT_RST;
            feature_count_reg = FEATURE_COUNT_RST;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            if (idx == REG_CLUSTER_COUNT)
                cluster_count_reg = data[CLUSTER_COUNT_W-1:0];
            else if (idx == REG_FEATURE_COUNT)
                feature_count_reg = data[FEATURE_COUNT_W-1:0];
        endfunction

        // register values as used, saturated into the legal range
        function int unsigned active_clusters();
            int unsigned n;
            n = cluster_count_reg;
            if (n < 1) return 1;
            if (n > NUM_CLUSTERS) return NUM_CLUSTERS;
            return n;
        endfunction

        function int unsigned active_features();
            int unsigned n;
            n = feature_count_reg;
            if (n < 1) return 1;
            if (n > NUM_FEATURES) return NUM_FEATURES;
            return n;
        endfunction

        function void take_item(func_t func, logic [CLUSTER_IDX_W-1:0] ci,
                                logic [FEATURE_IDX_W-1:0] fi,
                                logic signed [VALUE_W-1:0] value);
            int unsigned     nf;
            int unsigned     nc;
            int unsigned     best;
            int              diff;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned best_dist;
            assignment_t     hit;
            if (func == FUNC_WRITE_CENTROID)
            begin
                if (ci < NUM_CLUSTERS && fi < NUM_FEATURES)
                    centroid_mem[int'(ci) * NUM_FEATURES + int'(fi)] = value;
                return;
            end
            nf = active_features();
            if (fi >= nf) return;
            for (int k = 0; k < NUM_CLUSTERS; k++)
            begin
                diff = int'(centroid_mem[k * NUM_FEATURES + int'(fi)]) - int'(value);
                if (diff < 0) diff = -diff;
                term = diff;
                term = term * term;
                acc = (fi == 0) ? 64'd0 : 64'(dist_acc[k]);
                acc = acc + term;
                if (acc > ACC_SAT) acc = ACC_SAT;
                dist_acc[k] = acc[ACC_W-1:0];
            end
            if (fi != nf - 1) return;
            nc = active_clusters();
            best = 0;
            best_dist = dist_acc[0];
            for (int k = 1; k < nc; k++)
            begin
                if (dist_acc[k] < best_dist)
                begin
                    best_dist = dist_acc[k];
                    best = k;
                end
            end
            if (best_dist > DIST_SAT) best_dist = DIST_SAT;
            hit.cluster = best[CLUSTER_OUT_W-1:0];
            hit.distance = best_dist[DIST_W-1:0];
            predicted_q = {predicted_q, hit};
            foreach (dist_acc[k]) dist_acc[k] = '0;
        endfunction

        function void compare_result(logic [CLUSTER_OUT_W-1:0] cluster,
                                     logic [DIST_W-1:0] distance);
            assignment_t want;
            if (predicted_q.size() == 0)
            begin
                $error("result item with nothing expected: %s %0d %s %0d",
                       "nearest_cluster", cluster, "distance_squared", distance);
                mismatches++;
                return;
            end
            want = predicted_q.pop_front();
            if (cluster !== want.cluster)
            begin
                $error("nearest_cluster expected %0d actual %0d", want.cluster, cluster);
                mismatches++;
            end
            if (distance !== want.distance)
            begin
                $error("distance_squared expected %0d actual %0d", want.distance, distance);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nca_sample_if sample_ch ();
    nca_result_if result_ch ();
    nca_cfg_if    cfg_ch ();

    nearest_centroid_assign #(
        .MAX_CLUSTERS (NUM_CLUSTERS),
        .MAX_FEATURES (NUM_FEATURES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // period of 4 time units
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    assignment_checker sb = new();

    int unsigned burst_left   = 0;
    int unsigned idle_cycles  = 0;
    bit          hold_request = 1'b0;

    // register settings walked by the random phases, extremes and out-of-range values included
    logic [CFG_DATA_W-1:0] cc_plan [PLAN_LEN] =
        '{5'd8, 5'd1, 5'd8, 5'd1, 5'd0, 5'd15, 5'd19, 5'd4, 5'd0};
    logic [CFG_DATA_W-1:0] fc_plan [PLAN_LEN] =
        '{5'd16, 5'd1, 5'd1, 5'd16, 5'd0, 5'd31, 5'd20, 5'd7, 5'd0};

    // all handshakes are sampled here, at the rising edge
    // results are checked before the same edge's input item is noted
    always @(posedge clk)
    begin : monitor
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_ch.valid && result_ch.ready)
            begin
                sb.compare_result(result_ch.nearest_cluster, result_ch.distance_squared);
                moved = 1'b1;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                sb.take_item(func_t'(sample_ch.func), sample_ch.cluster_index,
                             sample_ch.feature_index, sample_ch.sample_value);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_register(cfg_ch.reg_index, cfg_ch.data);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: too long without any accepted item
    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(negedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: its own stall pattern, redrawn at random from four modes, plus one long hold-off on request
    initial
    begin
        int unsigned tick;
        rx_mode_t    mode;
        tick = 0;
        mode = RX_OPEN;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // block fills up behind a result that nobody takes
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (tick % 64 == 0) mode = rx_mode_t'($urandom_range(0, 3));
                case (mode)
                    RX_OPEN:     result_ch.ready = 1'b1;
                    RX_COIN:     result_ch.ready = 1'($urandom_range(0, 1));
                    RX_SPARSE:   result_ch.ready = ($urandom_range(0, 3) == 0);
                    default:     result_ch.ready = (tick % 5 < 2);
                endcase
                tick++;
            end
        end
    end

    // mixture of extremes, small values and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return '1;
            4:       return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // a feature close to one centroid's element, so that argmins and near ties are common
    function automatic logic signed [VALUE_W-1:0] near_value(int unsigned target,
                                                             int unsigned fi);
        int delta;
        if ($urandom_range(0, 2) == 0) return pick_value();
        delta = int'($urandom_range(0, 32)) - 16;
        return 16'(int'(sb.centroid_mem[target * NUM_FEATURES + fi]) + delta);
    endfunction

    // sender: bursts of random length with random gaps; valid stays high within a burst
    task automatic send_item(input func_t f, input logic [CLUSTER_IDX_W-1:0] ci,
                             input logic [FEATURE_IDX_W-1:0] fi,
                             input logic signed [VALUE_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
            @(negedge clk);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        else
        begin
            @(negedge clk);
        end
        sample_ch.func          = f;
        sample_ch.cluster_index = ci;
        sample_ch.feature_index = fi;
        sample_ch.sample_value  = v;
        sample_ch.valid         = 1'b1;
        burst_left--;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic feature(input int unsigned fi, input logic signed [VALUE_W-1:0] v);
        send_item(FUNC_FEATURE, 3'($urandom), 4'(fi), v);
    endtask

    task automatic centroid(input int unsigned ci, input int unsigned fi,
                            input logic signed [VALUE_W-1:0] v);
        send_item(FUNC_WRITE_CENTROID, 3'(ci), 4'(fi), v);
    endtask

    // lower valid, let every expected result arrive, then let the datapath drain
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        burst_left = 0;
        while (sb.predicted_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_ch.reg_index = idx;
        cfg_ch.data      = data;
        cfg_ch.valid     = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_counts(input logic [CFG_DATA_W-1:0] cc,
                              input logic [CFG_DATA_W-1:0] fc);
        write_register(REG_CLUSTER_COUNT, cc);
        write_register(REG_FEATURE_COUNT, fc);
    endtask

    // one sample in index order; a mangled one is cut short or gets a stray feature
    task automatic send_sample(input bit mangled, output int unsigned counted);
        int unsigned nf;
        int unsigned target;
        int unsigned cut;
        int unsigned spot;
        int unsigned extra_idx;
        nf = sb.active_features();
        target = $urandom_range(0, sb.active_clusters() - 1);
        counted = 0;
        cut = nf;
        spot = nf;
        extra_idx = 0;
        if (mangled)
        begin
            if ($urandom_range(0, 1))
                cut = $urandom_range(0, nf - 1);
            else
            begin
                spot = $urandom_range(0, nf - 1);
                extra_idx = $urandom_range(0, NUM_FEATURES - 1);
            end
        end
        for (int unsigned i = 0; i < cut; i++)
        begin
            if (i == spot)
            begin
                // restart, out-of-order repeat, early last feature, or beyond the sample
                feature(extra_idx, pick_value());
                if (extra_idx < nf) counted++;
            end
            feature(i, near_value(target, i));
            counted++;
        end
    endtask

    // column of extreme centroids, then one element repeated to build up large sums
    task automatic run_saturation(input int unsigned repeats);
        for (int k = 0; k < NUM_CLUSTERS; k++) centroid(k, SAT_COL, MOST_NEG);
        feature(0, pick_value());
        repeat (repeats) feature(SAT_COL, MOST_POS);
        feature(NUM_FEATURES - 1, pick_value());
        for (int k = 0; k < NUM_CLUSTERS; k++) centroid(k, SAT_COL, pick_value());
    endtask

    task automatic run_random_phase(input int unsigned budget);
        int unsigned done;
        int unsigned got;
        int unsigned choice;
        int unsigned fi;
        done = 0;
        while (done < budget)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 70)
            begin
                send_sample(1'b0, got);
                done += got;
            end
            else if (choice < 80)
            begin
                send_sample(1'b1, got);
                done += got;
            end
            else if (choice < 92)
            begin
                // rewrites keep every entry defined
                repeat ($urandom_range(1, 4))
                begin
                    centroid($urandom_range(0, NUM_CLUSTERS - 1),
                             $urandom_range(0, NUM_FEATURES - 1), pick_value());
                    done++;
                end
            end
            else
            begin
                // lone feature anywhere; ignored ones do not count
                fi = $urandom_range(0, NUM_FEATURES - 1);
                feature(fi, pick_value());
                if (fi < sb.active_features()) done++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        sample_ch.valid         = 1'b0;
        sample_ch.func          = FUNC_WRITE_CENTROID;
        sample_ch.cluster_index = '0;
        sample_ch.feature_index = '0;
        sample_ch.sample_value  = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.reg_index        = REG_CLUSTER_COUNT;
        cfg_ch.data             = '0;
        rst_n                   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every centroid entry is written before any feature reads it
        for (int c = 0; c < NUM_CLUSTERS; c++)
            for (int f = 0; f < NUM_FEATURES; f++)
                centroid(c, f, pick_value());

        // directed: short samples at full cluster count
        set_counts(5'd8, 5'd4);
        centroid(7, 15, MOST_POS);
        centroid(0, 0, MOST_NEG);
        // value extremes
        feature(0, MOST_NEG);
        feature(1, MOST_POS);
        feature(2, '0);
        feature(3, '1);
        // index 0 in mid sample starts it over
        feature(0, pick_value());
        feature(1, pick_value());
        feature(0, pick_value());
        feature(1, pick_value());
        feature(2, pick_value());
        feature(3, pick_value());
        // out of order, and a feature beyond the sample that is ignored
        feature(0, pick_value());
        feature(2, pick_value());
        feature(9, pick_value());
        feature(2, pick_value());
        feature(1, pick_value());
        feature(3, pick_value());

        // one feature per sample: each is first and last; ties go to the lowest index
        set_counts(5'd8, 5'd1);
        for (int k = 0; k < NUM_CLUSTERS; k++)
            centroid(k, 0, (k == 2 || k == 5) ? 16'sd3000 : 16'sd20000);
        feature(0, 16'sd3000);
        feature(7, pick_value());
        feature(0, 16'sd20000);

        // accumulator saturation, and distance saturation alone
        set_counts(5'd8, 5'd16);
        run_saturation(40);
        run_saturation(17);

        // undecoded register indexes change nothing
        write_register(REG_SPARE_A, 5'($urandom));
        write_register(REG_SPARE_B, 5'h1F);

        for (int p = 0; p < PLAN_LEN; p++)
        begin
            if (p == PLAN_LEN - 1)
                set_counts(5'($urandom), 5'($urandom));
            else
                set_counts(cc_plan[p], fc_plan[p]);
            // receiver holds off once while the sender keeps offering items
            if (p == 0) hold_request = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.predicted_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            if (sb.predicted_q.size() != 0)
                $error("%0d expected result items never arrived", sb.predicted_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
